// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker module of the maze row generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define EMRG_ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define EMRG_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/emrg_pkg.sv -----
// ----------------------------------------------------------------------------
// emrg_pkg
// Types and constants shared by the maze row generator modules.
// ----------------------------------------------------------------------------
package emrg_pkg;

    localparam int WIDTH_DEFAULT = 16;
    localparam int MERGE_W       = 15;
    localparam int DOWN_W        = 16;
    localparam int DATA_W        = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRESH,
        ST_MERGE,
        ST_FORCE,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHL,
        OP_SHR,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     relabel;
    } t_cell_ctl;

endpackage

// ----- rtl/core/emrg_cell.sv -----
// ----------------------------------------------------------------------------
// emrg_cell
// One column of the row: set label, label valid flag and the column's merge
// and down requests, shifted to either neighbor with optional set relabeling.
// ----------------------------------------------------------------------------
module emrg_cell #(
    parameter int LW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  emrg_pkg::t_cell_ctl  i_ctl,
    input  logic [LW-1:0]        i_from_label,
    input  logic [LW-1:0]        i_to_label,
    input  logic                 i_load_dreq,
    input  logic                 i_load_mreq,
    input  logic [LW-1:0]        i_rn_label,
    input  logic                 i_rn_valid,
    input  logic                 i_rn_dreq,
    input  logic                 i_rn_mreq,
    input  logic [LW-1:0]        i_ln_label,
    input  logic                 i_ln_valid,
    input  logic                 i_ln_dreq,
    input  logic                 i_ln_mreq,
    output logic [LW-1:0]        o_label,
    output logic                 o_valid,
    output logic                 o_dreq,
    output logic                 o_mreq
);

    logic [LW-1:0] r_label;
    logic          r_valid;
    logic          r_dreq;
    logic          r_mreq;

    logic [LW-1:0] sel_label;
    logic          sel_valid;
    logic          sel_dreq;
    logic          sel_mreq;
    logic [LW-1:0] new_label;

    always_comb begin
        if (i_ctl.op == emrg_pkg::OP_SHL) begin
            sel_label = i_rn_label;
            sel_valid = i_rn_valid;
            sel_dreq  = i_rn_dreq;
            sel_mreq  = i_rn_mreq;
        end else begin
            sel_label = i_ln_label;
            sel_valid = i_ln_valid;
            sel_dreq  = i_ln_dreq;
            sel_mreq  = i_ln_mreq;
        end
        if (i_ctl.relabel && sel_valid && (sel_label == i_from_label)) begin
            new_label = i_to_label;
        end else begin
            new_label = sel_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                emrg_pkg::OP_SHL,
                emrg_pkg::OP_SHR:   r_valid <= sel_valid;
                emrg_pkg::OP_CLEAR: r_valid <= 1'b0;
                default:            r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            emrg_pkg::OP_LOAD: begin
                r_dreq <= i_load_dreq;
                r_mreq <= i_load_mreq;
            end
            emrg_pkg::OP_SHL,
            emrg_pkg::OP_SHR: begin
                r_label <= new_label;
                r_dreq  <= sel_dreq;
                r_mreq  <= sel_mreq;
            end
            default: begin
                r_label <= r_label;
                r_dreq  <= r_dreq;
                r_mreq  <= r_mreq;
            end
        endcase
    end

    assign o_label = r_label;
    assign o_valid = r_valid;
    assign o_dreq  = r_dreq;
    assign o_mreq  = r_mreq;

endmodule

// ----- rtl/core/emrg_ctrl.sv -----
// ----------------------------------------------------------------------------
// emrg_ctrl
// Sequencer for the cell ring: fresh labels, merge scan, forced down
// openings, per-label bookkeeping and the result register.
// ----------------------------------------------------------------------------
module emrg_ctrl #(
    parameter  int WIDTH = emrg_pkg::WIDTH_DEFAULT,
    localparam int LW    = $clog2(WIDTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_in_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WIDTH-1:0]     o_right,
    output logic [WIDTH-1:0]     o_down,
    input  logic [LW-1:0]        i_head_label,
    input  logic                 i_head_valid,
    input  logic                 i_head_dreq,
    input  logic                 i_head_mreq,
    input  logic [LW-1:0]        i_next_label,
    input  logic [LW-1:0]        i_tail_label,
    input  logic                 i_tail_valid,
    input  logic                 i_tail_dreq,
    output logic [LW-1:0]        o_head_label,
    output logic                 o_head_valid,
    output logic                 o_tail_valid,
    output emrg_pkg::t_cell_ctl  o_ctl,
    output logic [LW-1:0]        o_from_label,
    output logic [LW-1:0]        o_to_label
);

    localparam logic [LW-1:0] LAST_STEP = LW'(WIDTH - 1);

    emrg_pkg::t_state r_state, n_state;
    logic [LW-1:0]    r_step, n_step;
    logic             r_last, n_last;
    logic [WIDTH-1:0] r_used, n_used;
    logic [WIDTH-1:0] r_hd, n_hd;
    logic [WIDTH-1:0] r_seen, n_seen;
    logic [WIDTH-1:0] r_right, n_right;
    logic [WIDTH-1:0] r_down, n_down;
    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_out_right, n_out_right;
    logic [WIDTH-1:0] r_out_down, n_out_down;

    logic [LW-1:0]    fresh_label;
    logic [WIDTH-1:0] head_bit;
    logic [WIDTH-1:0] tail_bit;
    logic [WIDTH-1:0] fresh_bit;
    logic [WIDTH-1:0] hd_acc;
    logic             do_merge;
    logic             tail_down;
    logic             step_end;

    always_comb begin
        fresh_label = '0;
        for (int k = WIDTH - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                fresh_label = LW'(k);
            end
        end
    end

    assign head_bit  = WIDTH'(1) << i_head_label;
    assign tail_bit  = WIDTH'(1) << i_tail_label;
    assign fresh_bit = WIDTH'(1) << fresh_label;
    assign step_end  = (r_step == LAST_STEP);
    assign do_merge  = !step_end && (i_head_label != i_next_label) &&
                       (r_last || i_head_mreq);
    assign hd_acc    = r_hd | (i_head_dreq ? head_bit : '0);
    assign tail_down = i_tail_dreq || (!r_seen[i_tail_label] && !r_hd[i_tail_label]);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_last       = r_last;
        n_used       = r_used;
        n_hd         = r_hd;
        n_seen       = r_seen;
        n_right      = r_right;
        n_down       = r_down;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_right  = r_out_right;
        n_out_down   = r_out_down;
        o_in_ready   = 1'b0;
        o_ctl        = '{op: emrg_pkg::OP_HOLD, relabel: 1'b0};
        o_from_label = i_next_label;
        o_to_label   = i_head_label;
        o_head_label = i_head_label;
        o_head_valid = i_head_valid;
        o_tail_valid = i_tail_valid;

        unique case (r_state)
            emrg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.op = emrg_pkg::OP_LOAD;
                    n_last   = i_in_last;
                    n_step   = '0;
                    n_hd     = '0;
                    n_seen   = '0;
                    n_right  = '0;
                    n_down   = '0;
                    n_state  = emrg_pkg::ST_FRESH;
                end
            end
            emrg_pkg::ST_FRESH: begin
                o_ctl.op     = emrg_pkg::OP_SHL;
                o_head_valid = 1'b1;
                if (!i_head_valid) begin
                    o_head_label = fresh_label;
                    n_used       = r_used | fresh_bit;
                end
                n_step = r_step + 1'b1;
                if (step_end) begin
                    n_step  = '0;
                    n_state = emrg_pkg::ST_MERGE;
                end
            end
            emrg_pkg::ST_MERGE: begin
                o_ctl.op      = emrg_pkg::OP_SHL;
                o_ctl.relabel = do_merge;
                n_right       = {do_merge, r_right[WIDTH-1:1]};
                n_hd          = hd_acc;
                if (do_merge) begin
                    n_hd[i_head_label] = hd_acc[i_head_label] | hd_acc[i_next_label];
                    n_hd[i_next_label] = 1'b0;
                end
                n_step = r_step + 1'b1;
                if (step_end) begin
                    n_step = '0;
                    if (r_last) begin
                        n_state = emrg_pkg::ST_DONE;
                    end else begin
                        n_used  = '0;
                        n_state = emrg_pkg::ST_FORCE;
                    end
                end
            end
            emrg_pkg::ST_FORCE: begin
                o_ctl.op     = emrg_pkg::OP_SHR;
                o_tail_valid = tail_down;
                n_seen       = r_seen | tail_bit;
                n_used       = r_used | (tail_down ? tail_bit : '0);
                n_down       = {r_down[WIDTH-2:0], tail_down};
                n_step       = r_step + 1'b1;
                if (step_end) begin
                    n_step  = '0;
                    n_state = emrg_pkg::ST_DONE;
                end
            end
            emrg_pkg::ST_DONE: begin
                if (r_last) begin
                    o_ctl.op = emrg_pkg::OP_CLEAR;
                    n_used   = '0;
                end
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_right = r_right;
                    n_out_down  = r_last ? '0 : r_down;
                    n_state     = emrg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = emrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= emrg_pkg::ST_IDLE;
            r_step      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_hd        <= n_hd;
        r_seen      <= n_seen;
        r_right     <= n_right;
        r_down      <= n_down;
        r_out_right <= n_out_right;
        r_out_down  <= n_out_down;
    end

    assign o_out_valid = r_out_valid;
    assign o_right     = r_out_right;
    assign o_down      = r_out_down;

endmodule

// ----- rtl/core/eller_maze_row_generator.sv -----
// ----------------------------------------------------------------------------
// eller_maze_row_generator
// Generates one maze row per input transfer with Eller's algorithm, keeping
// the set label of every column in a ring of column cells.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: merge_bits, down_bits; tlast: last_row
//   m_axis    out        tdata: right_open, down_open
//
// A row runs from input transfer to the result register as passes of the
// ring (fresh labels, merge scan, forced down openings; the last row skips
// the forced down pass); the ring rotates once per pass, one column a cycle.
// The next input transfer is taken once the row reaches the result register,
// also while a result waits there; a row stalls only until that register frees.
// Reset is synchronous and leaves every column unlabeled.
// ----------------------------------------------------------------------------
module eller_maze_row_generator #(
    parameter int WIDTH = emrg_pkg::WIDTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [14:0] merge_bits, [30:15] down_bits, [31] zero
    input  logic [emrg_pkg::DATA_W-1:0] i_s_axis_tdata,
    input  logic                        i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [14:0] right_open, [30:15] down_open, [31] zero
    output logic [emrg_pkg::DATA_W-1:0] o_m_axis_tdata
);

    localparam int LW = $clog2(WIDTH);

    logic [LW-1:0]        lbl [WIDTH];
    logic [WIDTH-1:0]     vld;
    logic [WIDTH-1:0]     dreq;
    logic [WIDTH-1:0]     mreq;

    emrg_pkg::t_cell_ctl  cell_ctl;
    logic [LW-1:0]        from_label;
    logic [LW-1:0]        to_label;
    logic [LW-1:0]        head_label;
    logic                 head_valid;
    logic                 tail_valid;
    logic [WIDTH-1:0]     right_vec;
    logic [WIDTH-1:0]     down_vec;
    logic [emrg_pkg::MERGE_W-1:0] right_open;
    logic [emrg_pkg::DOWN_W-1:0]  down_open;

    for (genvar k = 0; k < WIDTH; k++) begin : g_cell
        logic [LW-1:0] rn_label;
        logic          rn_valid;
        logic          rn_dreq;
        logic          rn_mreq;
        logic [LW-1:0] ln_label;
        logic          ln_valid;
        logic          ln_dreq;
        logic          ln_mreq;
        logic          ld_dreq;
        logic          ld_mreq;

        if (k == WIDTH - 1) begin : g_rn_head
            assign rn_label = head_label;
            assign rn_valid = head_valid;
            assign rn_dreq  = dreq[0];
            assign rn_mreq  = mreq[0];
        end else begin : g_rn_next
            assign rn_label = lbl[k+1];
            assign rn_valid = vld[k+1];
            assign rn_dreq  = dreq[k+1];
            assign rn_mreq  = mreq[k+1];
        end

        if (k == 0) begin : g_ln_tail
            assign ln_label = lbl[WIDTH-1];
            assign ln_valid = tail_valid;
            assign ln_dreq  = dreq[WIDTH-1];
            assign ln_mreq  = mreq[WIDTH-1];
        end else begin : g_ln_prev
            assign ln_label = lbl[k-1];
            assign ln_valid = vld[k-1];
            assign ln_dreq  = dreq[k-1];
            assign ln_mreq  = mreq[k-1];
        end

        if (k < emrg_pkg::MERGE_W) begin : g_ld_merge
            assign ld_mreq = i_s_axis_tdata[k];
        end else begin : g_ld_merge_zero
            assign ld_mreq = 1'b0;
        end

        if (k < emrg_pkg::DOWN_W) begin : g_ld_down
            assign ld_dreq = i_s_axis_tdata[emrg_pkg::MERGE_W+k];
        end else begin : g_ld_down_zero
            assign ld_dreq = 1'b0;
        end

        emrg_cell #(
            .LW (LW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_from_label (from_label),
            .i_to_label   (to_label),
            .i_load_dreq  (ld_dreq),
            .i_load_mreq  (ld_mreq),
            .i_rn_label   (rn_label),
            .i_rn_valid   (rn_valid),
            .i_rn_dreq    (rn_dreq),
            .i_rn_mreq    (rn_mreq),
            .i_ln_label   (ln_label),
            .i_ln_valid   (ln_valid),
            .i_ln_dreq    (ln_dreq),
            .i_ln_mreq    (ln_mreq),
            .o_label      (lbl[k]),
            .o_valid      (vld[k]),
            .o_dreq       (dreq[k]),
            .o_mreq       (mreq[k])
        );
    end

    emrg_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_last    (i_s_axis_tlast),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_right      (right_vec),
        .o_down       (down_vec),
        .i_head_label (lbl[0]),
        .i_head_valid (vld[0]),
        .i_head_dreq  (dreq[0]),
        .i_head_mreq  (mreq[0]),
        .i_next_label (lbl[1]),
        .i_tail_label (lbl[WIDTH-1]),
        .i_tail_valid (vld[WIDTH-1]),
        .i_tail_dreq  (dreq[WIDTH-1]),
        .o_head_label (head_label),
        .o_head_valid (head_valid),
        .o_tail_valid (tail_valid),
        .o_ctl        (cell_ctl),
        .o_from_label (from_label),
        .o_to_label   (to_label)
    );

    for (genvar k = 0; k < emrg_pkg::MERGE_W; k++) begin : g_right_out
        if (k < WIDTH - 1) begin : g_bit
            assign right_open[k] = right_vec[k];
        end else begin : g_zero
            assign right_open[k] = 1'b0;
        end
    end

    for (genvar k = 0; k < emrg_pkg::DOWN_W; k++) begin : g_down_out
        if (k < WIDTH) begin : g_bit
            assign down_open[k] = down_vec[k];
        end else begin : g_zero
            assign down_open[k] = 1'b0;
        end
    end

    assign o_m_axis_tdata = {1'b0, down_open, right_open};

endmodule

// ----- rtl/core/emrg_checker.sv -----
// ----------------------------------------------------------------------------
// emrg_checker
// Port-level checks for the maze row generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module emrg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [emrg_pkg::DATA_W-1:0] o_m_axis_tdata
);

    // Only one row is in work at a time.
    `EMRG_ASSERT_CLK(a_one_row, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready, "input taken while a row is in work")

    // A result is never presented in the cycle after an input transfer.
    `EMRG_ASSERT_CLK(a_no_early_out, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> !$rose(o_m_axis_tvalid), "result appeared right after input transfer")

    // A stalled result keeps its data.
    `EMRG_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "stalled result changed")

    // Reset leaves the block ready with no result pending.
    `EMRG_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready), "bad state after reset")

endmodule

bind eller_maze_row_generator emrg_checker u_emrg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
